>>> design/sdcr_pkg.sv
// Shared types, codes and helpers for the SIO disk command responder.
package sdcr_pkg;

    localparam int NUM_DRIVES = 4;

    // Input function codes (carried on s_tuser)
    localparam logic [1:0] FN_CMD    = 2'd0;
    localparam logic [1:0] FN_FETCH  = 2'd1;
    localparam logic [1:0] FN_SECTOR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MOUNTED = 3'd0;
    localparam logic [2:0] REG_DENSE   = 3'd1;
    localparam logic [2:0] REG_COUNT_1 = 3'd2;
    localparam logic [2:0] REG_COUNT_2 = 3'd3;
    localparam logic [2:0] REG_COUNT_3 = 3'd4;
    localparam logic [2:0] REG_COUNT_4 = 3'd5;

    // Bus bytes
    localparam logic [7:0] B_ACK      = 8'h41;
    localparam logic [7:0] B_NAK      = 8'h4E;
    localparam logic [7:0] B_COMPLETE = 8'h43;
    localparam logic [7:0] B_ERROR    = 8'h45;
    localparam logic [7:0] OP_READ    = 8'h52;
    localparam logic [7:0] OP_STATUS  = 8'h53;
    localparam logic [7:0] OP_SPEED   = 8'h3F;
    localparam logic [7:0] ID_FIRST   = 8'h31;

    // Status reply bytes
    localparam logic [7:0] ST_BASE  = 8'h10;
    localparam logic [7:0] ST_DENSE = 8'h20;
    localparam logic [7:0] ST_B1    = 8'hFF;
    localparam logic [7:0] ST_B2    = 8'hE0;
    localparam logic [7:0] ST_B3    = 8'h00;

    // Image layout
    localparam logic [23:0] HDR_BYTES   = 24'd16;
    localparam logic [23:0] BOOT_BYTES  = 24'd384;
    localparam logic [8:0]  LEN_SINGLE  = 9'd128;
    localparam logic [8:0]  LEN_DOUBLE  = 9'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [3:0]       mounted;
        logic [3:0]       dense;
        logic [3:0][15:0] count;
    } cfg_t;

    // Response jobs handed from front to back
    typedef enum logic [3:0] {
        J_NAK, J_STATUS, J_SPEED, J_RD_ERR, J_RD_REQ,
        J_COMPLETE, J_ERROR, J_BYTE, J_BYTE_SUM
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;     // status byte or echoed data byte
        logic [7:0]  aux;      // checksum byte
        logic [1:0]  drive;
        logic [23:0] offset;
        logic [8:0]  length;
    } job_t;

    // End-around-carry add
    function automatic logic [7:0] eac_add(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, s} + {1'b0, b};
        return sum[8] ? (sum[7:0] + 8'd1) : sum[7:0];
    endfunction

endpackage

>>> design/sio_disk_command_responder.sv
// SIO disk command responder: top level with configuration registers.
// The first reply item passes through the job queue, the back end's job register and its output register.
// Throughput: one input item per cycle while the 4-entry job queue has room; the
// output register sends one item per cycle while m_tready is high, with a bubble
// when the back end starts from empty. A status reply holds the back end until all its items are sent.
// Reset (aresetn low, synchronous) clears config, frame state, read phase and queue.
module sio_disk_command_responder import sdcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd_byte[7:0], cmd_index[15:8], fetch_ok[16],
                                   // sector_byte[24:17], zero fill
    input  logic [1:0]  s_tuser,   // func[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_byte[7:0], fetch_drive[9:8], fetch_offset[33:10],
                                   // fetch_length[42:34], zero fill
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    cfg_t cfg_reg, cfg_next;

    // Register writes; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_MOUNTED: cfg_next.mounted  = cfg_wdata[3:0];
                REG_DENSE:   cfg_next.dense    = cfg_wdata[3:0];
                REG_COUNT_1: cfg_next.count[0] = cfg_wdata;
                REG_COUNT_2: cfg_next.count[1] = cfg_wdata;
                REG_COUNT_3: cfg_next.count[2] = cfg_wdata;
                REG_COUNT_4: cfg_next.count[3] = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic  q_full;
    logic  push;
    job_t  push_job;
    logic  pop;
    logic  head_valid;
    job_t  head_job;
    logic  accept;

    // Front only sees an item when the queue can take its job
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    sdcr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (accept),
        .in_func        (s_tuser),
        .in_cmd_byte    (s_tdata[7:0]),
        .in_cmd_index   (s_tdata[15:8]),
        .in_fetch_ok    (s_tdata[16]),
        .in_sector_byte (s_tdata[24:17]),
        .push           (push),
        .push_job       (push_job)
    );

    sdcr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    logic [7:0]  tx_byte;
    logic [1:0]  fetch_drive;
    logic [23:0] fetch_offset;
    logic [8:0]  fetch_length;

    sdcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_tx     (tx_byte),
        .out_drive  (fetch_drive),
        .out_offset (fetch_offset),
        .out_length (fetch_length),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, fetch_length, fetch_offset, fetch_drive, tx_byte};

endmodule

>>> design/sdcr_front.sv
// Front end: frame assembly, frame check, read phase tracking, job generation.
module sdcr_front import sdcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [1:0]  in_func,
    input  logic [7:0]  in_cmd_byte,
    input  logic [7:0]  in_cmd_index,
    input  logic        in_fetch_ok,
    input  logic [7:0]  in_sector_byte,
    output logic        push,
    output job_t        push_job
);

    typedef enum logic [1:0] {PH_IDLE, PH_AWAIT, PH_STREAM} phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  store_reg [4];
    logic        store_we;
    logic [2:0]  fill_reg, fill_next;
    logic        open_reg, open_next;
    logic [7:0]  fsum_reg, fsum_next;      // running frame checksum
    logic [7:0]  rsum_reg, rsum_next;      // running reply checksum
    logic [8:0]  left_reg, left_next;

    // Frame decode (valid once four bytes are stored)
    logic [7:0]  id_off;
    logic        drv_ok;
    logic [1:0]  drv;
    logic        dense;
    logic [15:0] sector;
    logic        sec_bad;
    logic [8:0]  size;
    logic [23:0] offset;
    logic [15:0] sec_m;
    logic [7:0]  st_byte;
    logic [8:0]  left_dec;
    logic [7:0]  rsum_add;

    always_comb begin
        id_off  = store_reg[0] - ID_FIRST;
        drv_ok  = (store_reg[0] >= ID_FIRST) && ({24'd0, id_off} < NUM_DRIVES);
        drv     = id_off[1:0];
        dense   = cfg.dense[drv];
        sector  = {store_reg[3], store_reg[2]};
        sec_bad = (sector == 16'd0) || (sector > cfg.count[drv]);
        if (sector <= 16'd3) begin
            size   = LEN_SINGLE;
            sec_m  = sector - 16'd1;
            offset = HDR_BYTES + ({8'd0, sec_m} << 7);
        end else begin
            size   = dense ? LEN_DOUBLE : LEN_SINGLE;
            sec_m  = sector - 16'd4;
            offset = HDR_BYTES + BOOT_BYTES + ({8'd0, sec_m} << (dense ? 8 : 7));
        end
        st_byte  = ST_BASE | (dense ? ST_DENSE : 8'h00);
        left_dec = (left_reg != 9'd0) ? (left_reg - 9'd1) : 9'd0;
        rsum_add = eac_add(rsum_reg, in_sector_byte);
    end

    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        open_next  = open_reg;
        fsum_next  = fsum_reg;
        rsum_next  = rsum_reg;
        left_next  = left_reg;
        store_we   = 1'b0;
        push       = 1'b0;
        push_job   = '{kind: J_NAK, data: 8'd0, aux: 8'd0, drive: 2'd0,
                       offset: 24'd0, length: 9'd0};
        if (in_valid) begin
            case (in_func)
                FN_CMD: begin
                    if (phase_reg == PH_IDLE) begin
                        if (in_cmd_index == 8'd0) begin
                            store_we  = 1'b1;
                            fill_next = 3'd1;
                            open_next = 1'b1;
                            fsum_next = in_cmd_byte;
                        end else if (open_reg && in_cmd_index == {5'd0, fill_reg}) begin
                            if (fill_reg < 3'd4) begin
                                store_we  = 1'b1;
                                fill_next = fill_reg + 3'd1;
                                fsum_next = eac_add(fsum_reg, in_cmd_byte);
                            end else begin
                                fill_next = 3'd0;
                                open_next = 1'b0;
                                if (drv_ok && cfg.mounted[drv]) begin
                                    push = 1'b1;
                                    if (fsum_reg != in_cmd_byte) begin
                                        push_job.kind = J_NAK;
                                    end else begin
                                        case (store_reg[1])
                                            OP_STATUS: begin
                                                push_job.kind = J_STATUS;
                                                push_job.data = st_byte;
                                                push_job.aux  = eac_add(eac_add(eac_add(
                                                    st_byte, ST_B1), ST_B2), ST_B3);
                                            end
                                            OP_SPEED: push_job.kind = J_SPEED;
                                            OP_READ: begin
                                                if (sec_bad) begin
                                                    push_job.kind = J_RD_ERR;
                                                end else begin
                                                    push_job.kind   = J_RD_REQ;
                                                    push_job.drive  = drv;
                                                    push_job.offset = offset;
                                                    push_job.length = size;
                                                    phase_next      = PH_AWAIT;
                                                    left_next       = size;
                                                    rsum_next       = 8'd0;
                                                end
                                            end
                                            default: push_job.kind = J_NAK;
                                        endcase
                                    end
                                end
                            end
                        end
                    end
                end
                FN_FETCH: begin
                    if (phase_reg == PH_AWAIT) begin
                        push = 1'b1;
                        if (in_fetch_ok) begin
                            push_job.kind = J_COMPLETE;
                            phase_next    = PH_STREAM;
                            rsum_next     = 8'd0;
                        end else begin
                            push_job.kind = J_ERROR;
                            phase_next    = PH_IDLE;
                            left_next     = 9'd0;
                        end
                    end
                end
                FN_SECTOR: begin
                    if (phase_reg == PH_STREAM) begin
                        push          = 1'b1;
                        push_job.data = in_sector_byte;
                        push_job.aux  = rsum_add;
                        rsum_next     = rsum_add;
                        left_next     = left_dec;
                        if (left_dec == 9'd0) begin
                            push_job.kind = J_BYTE_SUM;
                            phase_next    = PH_IDLE;
                        end else begin
                            push_job.kind = J_BYTE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fill_reg  <= 3'd0;
            open_reg  <= 1'b0;
            fsum_reg  <= 8'd0;
            rsum_reg  <= 8'd0;
            left_reg  <= 9'd0;
        end else begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            open_reg  <= open_next;
            fsum_reg  <= fsum_next;
            rsum_reg  <= rsum_next;
            left_reg  <= left_next;
        end
    end

    // Frame bytes: no reset, only read after a full frame is stored
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[fill_next[1:0] - 2'd1] <= in_cmd_byte;
        end
    end

endmodule

>>> design/sdcr_queue.sv
// Job queue between front and back.
module sdcr_queue import sdcr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output job_t  head_job
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    always_comb begin
        full       = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
        head_valid = (cnt_reg != '0);
        head_job   = mem_reg[rd_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next   = cnt_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

>>> design/sdcr_back.sv
// Back end: expands each job into its reply items and drives the output register.
module sdcr_back import sdcr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         head_valid,
    input  job_t         head_job,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_kind,
    output logic [7:0]   out_tx,
    output logic [1:0]   out_drive,
    output logic [23:0]  out_offset,
    output logic [8:0]   out_length,
    output logic         out_last
);

    logic        busy_reg, busy_next;
    job_t        job_reg, job_next;
    logic [2:0]  step_reg, step_next;
    logic        ov_reg, ov_next;
    logic        ok_reg;
    logic [7:0]  tx_reg;
    logic [1:0]  drv_reg;
    logic [23:0] off_reg;
    logic [8:0]  len_reg;
    logic        last_reg;
    logic        load;

    // Current item from job and step
    logic        it_kind;
    logic [7:0]  it_tx;
    logic        it_last;
    logic        it_end;     // final item of the job, not always a reply's last

    always_comb begin
        it_kind = 1'b0;
        it_tx   = 8'd0;
        it_last = 1'b0;
        case (job_reg.kind)
            J_NAK: begin
                it_tx   = B_NAK;
                it_last = 1'b1;
            end
            J_STATUS: begin
                case (step_reg)
                    3'd0:    it_tx = B_ACK;
                    3'd1:    it_tx = B_COMPLETE;
                    3'd2:    it_tx = job_reg.data;
                    3'd3:    it_tx = ST_B1;
                    3'd4:    it_tx = ST_B2;
                    3'd5:    it_tx = ST_B3;
                    default: begin
                        it_tx   = job_reg.aux;
                        it_last = 1'b1;
                    end
                endcase
            end
            J_SPEED: begin
                case (step_reg)
                    3'd0:    it_tx = B_ACK;
                    3'd1:    it_tx = B_COMPLETE;
                    3'd2:    it_tx = 8'd0;
                    default: it_last = 1'b1;
                endcase
            end
            J_RD_ERR: begin
                if (step_reg == 3'd0) begin
                    it_tx = B_ACK;
                end else begin
                    it_tx   = B_ERROR;
                    it_last = 1'b1;
                end
            end
            J_RD_REQ: begin
                if (step_reg == 3'd0) begin
                    it_tx = B_ACK;
                end else begin
                    it_kind = 1'b1;
                    it_last = 1'b1;
                end
            end
            J_COMPLETE: it_tx = B_COMPLETE;
            J_ERROR: begin
                it_tx   = B_ERROR;
                it_last = 1'b1;
            end
            J_BYTE:     it_tx = job_reg.data;
            J_BYTE_SUM: begin
                if (step_reg == 3'd0) begin
                    it_tx = job_reg.data;
                end else begin
                    it_tx   = job_reg.aux;
                    it_last = 1'b1;
                end
            end
            default: it_last = 1'b1;
        endcase
        // single-item jobs that sit inside a longer reply
        it_end = it_last || (job_reg.kind inside {J_COMPLETE, J_BYTE});
    end

    always_comb begin
        busy_next = busy_reg;
        job_next  = job_reg;
        step_next = step_reg;
        pop       = 1'b0;
        load      = busy_reg && (!ov_reg || out_ready);
        ov_next   = load ? 1'b1 : (ov_reg && !out_ready);
        if (load) begin
            if (it_end) begin
                pop       = head_valid;
                busy_next = head_valid;
                job_next  = head_job;
                step_next = 3'd0;
            end else begin
                step_next = step_reg + 3'd1;
            end
        end else if (!busy_reg && head_valid) begin
            pop       = 1'b1;
            busy_next = 1'b1;
            job_next  = head_job;
            step_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (load) begin
            ok_reg   <= it_kind;
            tx_reg   <= it_tx;
            drv_reg  <= it_kind ? job_reg.drive : 2'd0;
            off_reg  <= it_kind ? job_reg.offset : 24'd0;
            len_reg  <= it_kind ? job_reg.length : 9'd0;
            last_reg <= it_last;
        end
    end

    assign out_valid  = ov_reg;
    assign out_kind   = ok_reg;
    assign out_tx     = tx_reg;
    assign out_drive  = drv_reg;
    assign out_offset = off_reg;
    assign out_length = len_reg;
    assign out_last   = last_reg;

endmodule

>>> verif/tb_sio_disk_command_responder.sv
// Self-checking testbench for the SIO disk command responder.
import sdcr_pkg::*;

// One result item as the block should send it.
typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [1:0]  drive;
    logic [23:0] offset;
    logic [8:0]  length;
    logic        fin;
} reply_t;

// Read state kept by the predictor
typedef enum logic [1:0] {RD_IDLE, RD_AWAIT, RD_STREAM} rd_phase_t;

// end-around-carry byte add
function automatic logic [7:0] add_eac(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
endfunction

// Drive-side predictor: mirrors the registers, assembles frames and keeps the
// read state, queues the replies each accepted item should cause.
class reply_board;
    logic [3:0]  mounted;
    logic [3:0]  dense;
    logic [15:0] count [4];

    logic [7:0]  frame [4];
    int unsigned fill;
    bit          open;
    rd_phase_t   ph;
    logic [7:0]  run_sum;
    int unsigned left;
    logic [1:0]  read_drive;

    reply_t      reply_q [$];
    int unsigned n_fail, n_seen, n_frames, n_streams;

    function new();
        mounted = '0;
        dense = '0;
        foreach (count[i]) count[i] = '0;
        fill = 0;
        open = 0;
        ph = RD_IDLE;
        run_sum = '0;
        left = 0;
        read_drive = '0;
        n_fail = 0;
        n_seen = 0;
        n_frames = 0;
        n_streams = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
        case (idx)
            REG_MOUNTED: mounted = v[3:0];
            REG_DENSE:   dense = v[3:0];
            REG_COUNT_1: count[0] = v;
            REG_COUNT_2: count[1] = v;
            REG_COUNT_3: count[2] = v;
            REG_COUNT_4: count[3] = v;
            default: ;
        endcase
    endfunction

    function void push_byte(logic [7:0] b, bit fin);
        reply_t r;
        r = '0;
        r.tx = b;
        r.fin = fin;
        reply_q.push_back(r);
    endfunction

    // Fifth byte arrived: judge the frame and queue the answer.
    function void evaluate(logic [7:0] chk);
        logic [7:0]  id, op, sum;
        logic [7:0]  stat [4];
        logic [1:0]  drv;
        logic [15:0] sector;
        int unsigned size, offs;
        reply_t      req;
        id = frame[0];
        op = frame[1];
        if (id < ID_FIRST || int'(id) - int'(ID_FIRST) >= NUM_DRIVES) return;
        drv = 2'(id - ID_FIRST);
        if (!mounted[drv]) return;
        n_frames++;
        sum = '0;
        for (int i = 0; i < 4; i++) sum = add_eac(sum, frame[i]);
        if (sum != chk || !(op == OP_READ || op == OP_STATUS || op == OP_SPEED)) begin
            push_byte(B_NAK, 1);
            return;
        end
        push_byte(B_ACK, 0);
        if (op == OP_STATUS) begin
            stat[0] = ST_BASE | (dense[drv] ? ST_DENSE : 8'h00);
            stat[1] = ST_B1;
            stat[2] = ST_B2;
            stat[3] = ST_B3;
            push_byte(B_COMPLETE, 0);
            sum = '0;
            for (int i = 0; i < 4; i++) begin
                push_byte(stat[i], 0);
                sum = add_eac(sum, stat[i]);
            end
            push_byte(sum, 1);
        end else if (op == OP_SPEED) begin
            push_byte(B_COMPLETE, 0);
            push_byte(8'h00, 0);
            push_byte(8'h00, 1);
        end else begin
            sector = {frame[3], frame[2]};
            if (sector == 0 || sector > count[drv]) begin
                push_byte(B_ERROR, 1);
                return;
            end
            // first three sectors are always short, after them the boot area ends
            if (sector <= 3) begin
                size = int'(LEN_SINGLE);
                offs = int'(HDR_BYTES) + (int'(sector) - 1) * int'(LEN_SINGLE);
            end else begin
                size = dense[drv] ? int'(LEN_DOUBLE) : int'(LEN_SINGLE);
                offs = int'(HDR_BYTES) + int'(BOOT_BYTES) + (int'(sector) - 4) * size;
            end
            req = '0;
            req.kind = 1'b1;
            req.drive = drv;
            req.offset = offs[23:0];
            req.length = size[8:0];
            req.fin = 1'b1;
            reply_q.push_back(req);
            ph = RD_AWAIT;
            read_drive = drv;
            left = size;
            run_sum = '0;
        end
    endfunction

    function void note_item(logic [1:0] fn, logic [31:0] d);
        logic [7:0] cb, ci, sbyte;
        logic       ok;
        cb = d[7:0];
        ci = d[15:8];
        ok = d[16];
        sbyte = d[24:17];
        case (fn)
            FN_CMD: begin
                // command bytes are dropped while a read is in progress
                if (ph == RD_IDLE) begin
                    if (ci == 0) begin
                        frame[0] = cb;
                        fill = 1;
                        open = 1;
                    end else if (open && ci == fill && fill < 5) begin
                        if (fill < 4) begin
                            frame[fill] = cb;
                            fill++;
                        end else begin
                            fill = 0;
                            open = 0;
                            evaluate(cb);
                        end
                    end
                end
            end
            FN_FETCH: begin
                if (ph == RD_AWAIT) begin
                    if (ok) begin
                        ph = RD_STREAM;
                        run_sum = '0;
                        push_byte(B_COMPLETE, 0);
                    end else begin
                        ph = RD_IDLE;
                        left = 0;
                        push_byte(B_ERROR, 1);
                    end
                end
            end
            FN_SECTOR: begin
                if (ph == RD_STREAM) begin
                    push_byte(sbyte, 0);
                    run_sum = add_eac(run_sum, sbyte);
                    if (left > 0) left--;
                    if (left == 0) begin
                        ph = RD_IDLE;
                        push_byte(run_sum, 1);
                        n_streams++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void cmp_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    function void check_reply(logic [47:0] d, logic u, logic l);
        reply_t want;
        n_seen++;
        if (reply_q.size() == 0) begin
            $error("unexpected result item: tdata=0x%h tuser=%b tlast=%b", d, u, l);
            n_fail++;
            return;
        end
        want = reply_q.pop_front();
        cmp_field("kind", 24'(want.kind), 24'(u));
        cmp_field("tx_byte", 24'(want.tx), 24'(d[7:0]));
        cmp_field("fetch_drive", 24'(want.drive), 24'(d[9:8]));
        cmp_field("fetch_offset", want.offset, d[33:10]);
        cmp_field("fetch_length", 24'(want.length), 24'(d[42:34]));
        cmp_field("last", 24'(want.fin), 24'(l));
    endfunction
endclass

module tb_sio_disk_command_responder;
    import sdcr_pkg::*;

    // function code the block does not use; must be ignored
    localparam logic [1:0] FN_SPARE = 2'd3;
    // run watchdog; a slow correct run stays far below this
    localparam int unsigned LIMIT = 1_000_000;
    // quiet cycles after the last reply, covers the reply latency with room
    localparam int unsigned DRAIN_PAD = 8;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    reply_board  sb;
    int unsigned n_sent = 0;
    int unsigned n_settings = 0;
    int unsigned cycles = 0;
    int unsigned calm_left = 0;   // cycles left in a no-idle stretch
    int unsigned stall_left = 0;  // receiver stall countdown

    sio_disk_command_responder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length shared by sender and receiver: mostly none or short, now and
    // then long, with occasional stretches of no gaps at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // tdata layout: cmd_byte, cmd_index, fetch_ok, sector_byte from bit 0 up
    function automatic logic [31:0] pack_item(input logic [7:0] cb, input logic [7:0] ci,
                                              input logic ok, input logic [7:0] sbyte);
        return {7'd0, sbyte, ok, ci, cb};
    endfunction

    // Present one item, hold it until the handshake, then tell the predictor.
    task automatic send_item(input logic [1:0] fn, input logic [31:0] d);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(fn, d);
        n_sent++;
    endtask

    // Command byte; the fields that belong to other functions carry junk.
    task automatic send_cmd(input logic [7:0] idx, input logic [7:0] b);
        send_item(FN_CMD, pack_item(b, idx, 1'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 255))));
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)),
                  pack_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] op,
                              input logic [7:0] a1, input logic [7:0] a2, input bit good);
        logic [7:0] chk;
        chk = add_eac(add_eac(add_eac(id, op), a1), a2);
        if (!good) chk = chk ^ 8'($urandom_range(1, 255));
        send_cmd(8'd0, id);
        send_cmd(8'd1, op);
        send_cmd(8'd2, a1);
        send_cmd(8'd3, a2);
        send_cmd(8'd4, chk);
    endtask

    // Sector numbers cluster on the edges: zero, short sectors, first long
    // sector, the drive's last sector and one past it, the top of the range.
    function automatic logic [15:0] pick_sector(input logic [1:0] drv);
        logic [15:0] top;
        top = sb.count[drv];
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2, 3: return 16'($urandom_range(1, 3));
            4:       return 16'd4;
            5:       return top;
            6:       return top + 16'd1;
            7:       return 16'hFFFF;
            default: return 16'($urandom_range(1, top == 0 ? 1 : top));
        endcase
    endfunction

    task automatic random_frame();
        logic [7:0]  id, op;
        logic [15:0] sec;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8) id = ID_FIRST + 8'($urandom_range(0, NUM_DRIVES - 1));
        else if (r == 8) id = 8'($urandom_range(0, 255));
        else id = $urandom_range(0, 1) ? ID_FIRST - 8'd1 : ID_FIRST + 8'(NUM_DRIVES);
        r = $urandom_range(0, 19);
        if (r < 9) op = OP_READ;
        else if (r < 13) op = OP_STATUS;
        else if (r < 16) op = OP_SPEED;
        else op = 8'($urandom_range(0, 255));
        sec = pick_sector(2'(id - ID_FIRST));
        send_frame(id, op, sec[7:0], sec[15:8], $urandom_range(0, 9) != 0);
    endtask

    // Frame cut short, optionally followed by a byte with the wrong index.
    task automatic broken_frame();
        int unsigned k;
        k = $urandom_range(1, 4);
        send_cmd(8'd0, ID_FIRST + 8'($urandom_range(0, NUM_DRIVES - 1)));
        for (int i = 1; i < k; i++) send_cmd(8'(i), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_cmd(8'(k + $urandom_range(1, 250)),
                                           8'($urandom_range(0, 255)));
    endtask

    // Random traffic steered by the read state so reads run to completion;
    // the rest is noise that the block must ignore or survive.
    task automatic random_part(input int unsigned budget);
        int unsigned start, r;
        start = n_sent;
        while (n_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (sb.ph == RD_STREAM) begin
                if (r < 92) send_item(FN_SECTOR,
                                      pack_item(8'($urandom_range(0, 255)),
                                                8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)),
                                                8'($urandom_range(0, 255))));
                else send_noise();
            end else if (sb.ph == RD_AWAIT) begin
                if (r < 80) send_item(FN_FETCH,
                                      pack_item(8'($urandom_range(0, 255)),
                                                8'($urandom_range(0, 255)),
                                                r < 60, 8'($urandom_range(0, 255))));
                else send_noise();
            end else begin
                if (r < 72) random_frame();
                else if (r < 84) broken_frame();
                else send_noise();
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input logic [3:0] mnt, input logic [3:0] den,
                             input logic [15:0] c1, input logic [15:0] c2,
                             input logic [15:0] c3, input logic [15:0] c4);
        write_reg(REG_MOUNTED, {12'd0, mnt});
        write_reg(REG_DENSE, {12'd0, den});
        write_reg(REG_COUNT_1, c1);
        write_reg(REG_COUNT_2, c2);
        write_reg(REG_COUNT_3, c3);
        write_reg(REG_COUNT_4, c4);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Stop sending, wait for every queued reply, then let the pipe go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** sio_disk_command_responder: FAILED **");
            $finish;
        end
    end

    // Result side: check on each handshake, then pick next cycle's tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser, m_tlast);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Drive 3 absent, drive 2 dense; counts at both extremes.
        configure(4'b1011, 4'b0010, 16'hFFFF, 16'd5, 16'd0, 16'd1);

        // Directed: status reply, read of sector zero, read whose fetch fails,
        // bad checksum, then lone items that must all be ignored.
        send_frame(ID_FIRST, OP_STATUS, 8'h00, 8'h00, 1);
        send_frame(ID_FIRST + 8'd3, OP_READ, 8'h00, 8'h00, 1);
        send_frame(ID_FIRST, OP_READ, 8'h01, 8'h00, 1);
        send_item(FN_FETCH, pack_item(8'hFF, 8'hFF, 1'b0, 8'hFF));
        send_frame(ID_FIRST + 8'd1, OP_SPEED, 8'hFF, 8'hFF, 0);
        send_item(FN_SPARE, pack_item(8'hFF, 8'hFF, 1'b1, 8'hFF));
        send_item(FN_FETCH, pack_item(8'h00, 8'h00, 1'b1, 8'h00));
        send_item(FN_SECTOR, pack_item(8'h00, 8'h00, 1'b0, 8'hFF));
        send_cmd(8'hFF, 8'hFF);   // no frame open
        random_part(30);

        // Everything mounted and dense: long sectors and high offsets.
        settle();
        configure(4'hF, 4'hF, 16'd3, 16'hFFFF, 16'd200, 16'd4);
        random_part(30);

        // Alternate drives only, all single density.
        settle();
        configure(4'b0101, 4'h0, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
        random_part(20);

        // Nothing mounted: frames get no answer, a pending read is still served.
        settle();
        configure(4'h0, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_part(10);

        settle();
        $display("Sent %0d input items under %0d register settings, checked %0d result items.",
                 n_sent, n_settings, sb.n_seen);
        $display("%0d frames reached a mounted drive, %0d sector reads streamed to the end.",
                 sb.n_frames, sb.n_streams);
        if (sb.n_fail == 0 && sb.reply_q.size() == 0) begin
            $display("** sio_disk_command_responder: PASSED **");
        end else begin
            if (sb.reply_q.size() != 0)
                $error("%0d result items never arrived", sb.reply_q.size());
            $display("** sio_disk_command_responder: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
design/sdcr_pkg.sv
design/sdcr_front.sv
design/sdcr_queue.sv
design/sdcr_back.sv
design/sio_disk_command_responder.sv
verif/tb_sio_disk_command_responder.sv
